@@ hw/rtl/selt_pkg.sv @@
// Shared types and codes for the shared/exclusive latch table.
// No dependencies; used by selt_core and shared_exclusive_latch_table.

package selt_pkg;

    typedef enum logic [1:0] {
        OP_ACQUIRE = 2'd0,
        OP_UPGRADE = 2'd1,
        OP_RELEASE = 2'd2,
        OP_QUERY   = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        ST_DONE       = 2'd0,
        ST_WAIT       = 2'd1,
        ST_NOT_HOLDER = 2'd2,
        ST_OVERFLOW   = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        MODE_NONE   = 2'd0,
        MODE_SHARED = 2'd1,
        MODE_EXCL   = 2'd2
    } t_mode;

    localparam logic [7:0] CNT_MAX = 8'hFF;

    typedef struct packed {
        logic [1:0] operation;
        logic [7:0] thread_id;
        logic       want_exclusive;
        logic       waiters_present;
    } t_in_word;

    typedef struct packed {
        logic [1:0] status;
        logic [7:0] hold_count;
        logic [1:0] latch_mode;
        logic [2:0] holder_count;
        logic [9:0] total_count;
        logic       wake_waiters;
    } t_out_word;

endpackage

@@ hw/rtl/selt_core.sv @@
// Holder slot table with its one-pass update: lookup, grant decision, compaction.
// Depends on selt_pkg.

module selt_core #(
    parameter int MAX_SHARERS = 4
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_step,
    input  selt_pkg::t_in_word  i_word,
    output selt_pkg::t_out_word o_word
);

    localparam int CW = $clog2(MAX_SHARERS + 1);

    logic [7:0]         r_owner [MAX_SHARERS];
    logic [7:0]         r_cnt   [MAX_SHARERS];
    logic [7:0]         n_owner [MAX_SHARERS];
    logic [7:0]         n_cnt   [MAX_SHARERS];
    selt_pkg::t_mode    r_mode, n_mode;
    logic [CW-1:0]      r_holders, n_holders;
    logic [9:0]         r_total, n_total;

    logic [MAX_SHARERS-1:0] occupied, hit, last, first_free;
    logic [7:0]  cnt_h, cnt_last, owner_last, cnt_dec, g_cnt_old, hold;
    logic        any_hit, occ_zero, occ_one, occ_full, tid_zero;
    logic        g_ok, g_new, overflow, grant, up_ok, rel_ok, freeing;
    selt_pkg::t_mode   g_mode;
    selt_pkg::t_status status;

    always_comb begin
        for (int i = 0; i < MAX_SHARERS; i++) begin
            occupied[i] = (r_cnt[i] != 8'd0);
            hit[i]      = occupied[i] && (r_owner[i] == i_word.thread_id);
        end
        last       = occupied & ~(occupied >> 1);
        first_free = ~occupied & {occupied[MAX_SHARERS-2:0], 1'b1};
        cnt_h      = '0;
        cnt_last   = '0;
        owner_last = '0;
        for (int i = 0; i < MAX_SHARERS; i++) begin
            cnt_h      = cnt_h      | (hit[i]  ? r_cnt[i]   : 8'd0);
            cnt_last   = cnt_last   | (last[i] ? r_cnt[i]   : 8'd0);
            owner_last = owner_last | (last[i] ? r_owner[i] : 8'd0);
        end
        any_hit  = |hit;
        occ_zero = !occupied[0];
        occ_one  = occupied[0] && !occupied[1];
        occ_full = occupied[MAX_SHARERS-1];
        tid_zero = (i_word.thread_id == 8'd0);
    end

    always_comb begin
        g_ok   = 1'b0;
        g_new  = 1'b0;
        g_mode = i_word.want_exclusive ? selt_pkg::MODE_EXCL : selt_pkg::MODE_SHARED;
        if (tid_zero) begin
            g_ok = 1'b0;
        end else if (occ_zero) begin
            g_ok  = 1'b1;
            g_new = 1'b1;
        end else if (r_mode == selt_pkg::MODE_EXCL) begin
            if (hit[0]) begin
                g_ok   = 1'b1;
                g_mode = selt_pkg::MODE_EXCL;
            end
        end else if (any_hit) begin
            g_ok = !i_word.want_exclusive || occ_one;
        end else if (!i_word.waiters_present && !occ_full && !i_word.want_exclusive) begin
            g_ok  = 1'b1;
            g_new = 1'b1;
        end
        g_cnt_old = g_new ? 8'd0 : cnt_h;
        overflow  = g_ok && (g_cnt_old == selt_pkg::CNT_MAX);
        up_ok     = any_hit && occ_one;
        rel_ok    = any_hit;
        cnt_dec   = cnt_h - 8'd1;
        freeing   = rel_ok && (cnt_dec == 8'd0);
        grant     = 1'b0;
        status    = selt_pkg::ST_DONE;
        case (selt_pkg::t_op'(i_word.operation))
            selt_pkg::OP_ACQUIRE: begin
                grant = g_ok && !overflow;
                if (!g_ok) begin
                    status = selt_pkg::ST_WAIT;
                end else if (overflow) begin
                    status = selt_pkg::ST_OVERFLOW;
                end
            end
            selt_pkg::OP_UPGRADE: begin
                if (!up_ok) begin
                    status = selt_pkg::ST_WAIT;
                end
            end
            selt_pkg::OP_RELEASE: begin
                if (!rel_ok) begin
                    status = selt_pkg::ST_NOT_HOLDER;
                end
            end
            default: begin
                status = selt_pkg::ST_DONE;
            end
        endcase
    end

    always_comb begin
        for (int i = 0; i < MAX_SHARERS; i++) begin
            n_owner[i] = r_owner[i];
            n_cnt[i]   = r_cnt[i];
            if (grant && g_new && first_free[i]) begin
                n_owner[i] = i_word.thread_id;
                n_cnt[i]   = 8'd1;
            end
            if (grant && !g_new && hit[i]) begin
                n_cnt[i] = r_cnt[i] + 8'd1;
            end
            if (i_word.operation == selt_pkg::OP_RELEASE) begin
                if (rel_ok && !freeing && hit[i]) begin
                    n_cnt[i] = cnt_dec;
                end
                if (freeing && hit[i]) begin
                    n_owner[i] = owner_last;
                    n_cnt[i]   = cnt_last;
                end
                if (freeing && last[i]) begin
                    n_cnt[i] = 8'd0;
                end
            end
        end
        n_mode    = r_mode;
        n_holders = r_holders;
        n_total   = r_total;
        hold      = any_hit ? cnt_h : 8'd0;
        case (selt_pkg::t_op'(i_word.operation))
            selt_pkg::OP_ACQUIRE: begin
                if (grant) begin
                    n_mode    = g_mode;
                    n_holders = r_holders + CW'(g_new);
                    n_total   = r_total + 10'd1;
                    hold      = g_cnt_old + 8'd1;
                end
            end
            selt_pkg::OP_UPGRADE: begin
                if (up_ok) begin
                    n_mode = selt_pkg::MODE_EXCL;
                end
            end
            selt_pkg::OP_RELEASE: begin
                if (rel_ok) begin
                    n_total = r_total - 10'd1;
                    hold    = cnt_dec;
                end
                if (freeing) begin
                    n_holders = r_holders - CW'(1);
                    if (occ_one) begin
                        n_mode = selt_pkg::MODE_NONE;
                    end
                end
            end
            default: begin
                n_mode = r_mode;
            end
        endcase
        o_word.status       = status;
        o_word.hold_count   = hold;
        o_word.latch_mode   = n_mode;
        o_word.holder_count = 3'(n_holders);
        o_word.total_count  = n_total;
        o_word.wake_waiters = (i_word.operation == selt_pkg::OP_RELEASE) && freeing;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < MAX_SHARERS; i++) begin
                r_cnt[i] <= 8'd0;
            end
            r_mode    <= selt_pkg::MODE_NONE;
            r_holders <= '0;
            r_total   <= '0;
        end else if (i_step) begin
            for (int i = 0; i < MAX_SHARERS; i++) begin
                r_cnt[i] <= n_cnt[i];
            end
            r_mode    <= n_mode;
            r_holders <= n_holders;
            r_total   <= n_total;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_step) begin
            for (int i = 0; i < MAX_SHARERS; i++) begin
                r_owner[i] <= n_owner[i];
            end
        end
    end

endmodule

@@ hw/rtl/shared_exclusive_latch_table.sv @@
// Top level of the shared/exclusive latch table: input register, result register, handshake.
// Depends on selt_pkg and selt_core.

// One word in, one result word out per request. The block takes a request
// every cycle while o_in_stall is low; an accepted request sits in the input
// register while the slot table update feeds its result into the result
// register. The slot table resolves each request in a single update, with
// all MAX_SHARERS slots compared in parallel. Holder and total counts are
// kept as running registers, and an output stall holds the result and backs
// up into the input side.

module shared_exclusive_latch_table #(
    parameter int MAX_SHARERS = 4
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  selt_pkg::t_in_word  i_in_word,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output selt_pkg::t_out_word o_out_word
);

    logic                r_in_vld;
    selt_pkg::t_in_word  r_in_word;
    logic                r_out_vld;
    selt_pkg::t_out_word r_out_word;
    selt_pkg::t_out_word w_res;
    logic                w_adv;

    assign w_adv      = r_in_vld && (!r_out_vld || !i_out_stall);
    assign o_in_stall = r_in_vld && !w_adv;

    selt_core #(
        .MAX_SHARERS(MAX_SHARERS)
    ) u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (w_adv),
        .i_word  (r_in_word),
        .o_word  (w_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            if (!o_in_stall) begin
                r_in_vld <= i_in_valid;
            end
            if (w_adv) begin
                r_out_vld <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_in_stall && i_in_valid) begin
            r_in_word <= i_in_word;
        end
        if (w_adv) begin
            r_out_word <= w_res;
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_out_word  = r_out_word;

`ifndef SYNTHESIS
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_vld && !w_adv) |=> (r_in_vld && $stable(r_in_word)))
        else $error("held request lost or changed");

    a_excl_sole: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_out_word.latch_mode == selt_pkg::MODE_EXCL))
            |-> (o_out_word.holder_count == 3'd1))
        else $error("exclusive mode with other than one holder");

    a_wake_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_word.wake_waiters)
            |-> (o_out_word.status == selt_pkg::ST_DONE && o_out_word.hold_count == 8'd0))
        else $error("wake without a completed release");
`endif

endmodule
